// ===== rtl/core/mau_pkg.sv =====
// shared types and constants of the multiply-accumulate unit
// no dependencies; used by every other file in rtl/core
package mau_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned HALF_W = 16;
    localparam int unsigned ACC_W  = 64;
    // operands are widened by one bit so one signed multiplier serves all modes
    localparam int unsigned OPND_W = WORD_W + 1;
    localparam int unsigned MODE_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_MUL_S16   = 3'd0,
        MODE_MUL_U16   = 3'd1,
        MODE_MUL_S32   = 3'd2,
        MODE_MUL_U32   = 3'd3,
        MODE_MAC       = 3'd4,
        MODE_LOAD_LOW  = 3'd5,
        MODE_LOAD_HIGH = 3'd6,
        MODE_LOAD_FLAG = 3'd7
    } mode_t;

    // decoded operands, held between the input stage and the multiplier
    typedef struct packed {
        mode_t             mode;
        logic [OPND_W-1:0] opnd_a;
        logic [OPND_W-1:0] opnd_b;
        logic [WORD_W-1:0] load_word;
    } opnd_stage_t;

    // product, held between the multiplier and the accumulator
    typedef struct packed {
        mode_t             mode;
        logic [ACC_W-1:0]  product;
        logic [WORD_W-1:0] load_word;
    } prod_stage_t;

endpackage

// ===== rtl/core/mau_if.sv =====
// valid/ready channel interfaces of the multiply-accumulate unit
// depends on mau_pkg for field widths
interface mau_req_if;
    logic                              valid;
    logic                              ready;
    logic [mau_pkg::MODE_W-1:0]        mode;
    logic [mau_pkg::WORD_W-1:0]        operand_a;
    logic [mau_pkg::WORD_W-1:0]        operand_b;

    modport source (output valid, output mode, output operand_a, output operand_b,
                    input ready);
    modport sink (input valid, input mode, input operand_a, input operand_b,
                  output ready);
endinterface

interface mau_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [mau_pkg::WORD_W-1:0]        acc_low;
    logic [mau_pkg::WORD_W-1:0]        acc_high;
    logic                              overflow;

    modport source (output valid, output acc_low, output acc_high, output overflow,
                    input ready);
    modport sink (input valid, input acc_low, input acc_high, input overflow,
                  output ready);
endinterface

// ===== rtl/core/mau_input_stage.sv =====
// input register: decodes the mode into widened multiplier operands
// depends on mau_pkg
module mau_input_stage
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                up_valid,
    input  logic [mau_pkg::MODE_W-1:0]          mode,
    input  logic [mau_pkg::WORD_W-1:0]          operand_a,
    input  logic [mau_pkg::WORD_W-1:0]          operand_b,
    output logic                                up_ready,
    input  logic                                down_ready,
    output logic                                stage_valid,
    output mau_pkg::opnd_stage_t                stage
);

    logic                 valid_reg;
    logic                 valid_next;
    mau_pkg::opnd_stage_t stage_reg;
    mau_pkg::opnd_stage_t stage_next;
    logic                 load;

    assign up_ready = !valid_reg || down_ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        stage_next           = '0;
        stage_next.mode      = mau_pkg::mode_t'(mode);
        stage_next.load_word = operand_a;
        unique case (mau_pkg::mode_t'(mode))
            mau_pkg::MODE_MUL_S16, mau_pkg::MODE_MAC:
            begin
                stage_next.opnd_a = {{(mau_pkg::OPND_W - mau_pkg::HALF_W){operand_a[15]}},
                                     operand_a[15:0]};
                stage_next.opnd_b = {{(mau_pkg::OPND_W - mau_pkg::HALF_W){operand_b[15]}},
                                     operand_b[15:0]};
            end
            mau_pkg::MODE_MUL_U16:
            begin
                stage_next.opnd_a = {{(mau_pkg::OPND_W - mau_pkg::HALF_W){1'b0}},
                                     operand_a[15:0]};
                stage_next.opnd_b = {{(mau_pkg::OPND_W - mau_pkg::HALF_W){1'b0}},
                                     operand_b[15:0]};
            end
            mau_pkg::MODE_MUL_S32:
            begin
                stage_next.opnd_a = {operand_a[31], operand_a};
                stage_next.opnd_b = {operand_b[31], operand_b};
            end
            mau_pkg::MODE_MUL_U32:
            begin
                stage_next.opnd_a = {1'b0, operand_a};
                stage_next.opnd_b = {1'b0, operand_b};
            end
            mau_pkg::MODE_LOAD_LOW, mau_pkg::MODE_LOAD_HIGH, mau_pkg::MODE_LOAD_FLAG:
            begin
                stage_next.opnd_a = '0;
                stage_next.opnd_b = '0;
            end
        endcase
    end

    assign valid_next = load ? 1'b1 : (valid_reg && !down_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

endmodule

// ===== rtl/core/mau_mul_stage.sv =====
// multiplier stage: one 33x33 signed multiply, product registered
// depends on mau_pkg
module mau_mul_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    input  mau_pkg::opnd_stage_t up_stage,
    output logic                 up_ready,
    input  logic                 down_ready,
    output logic                 stage_valid,
    output mau_pkg::prod_stage_t stage
);

    logic                                  valid_reg;
    logic                                  valid_next;
    mau_pkg::prod_stage_t                  stage_reg;
    mau_pkg::prod_stage_t                  stage_next;
    logic signed [2*mau_pkg::OPND_W-1:0]   full_product;
    logic                                  load;

    assign up_ready = !valid_reg || down_ready;
    assign load     = up_valid && up_ready;

    assign full_product = $signed(up_stage.opnd_a) * $signed(up_stage.opnd_b);

    always_comb
    begin
        stage_next.mode      = up_stage.mode;
        stage_next.product   = full_product[mau_pkg::ACC_W-1:0];
        stage_next.load_word = up_stage.load_word;
    end

    assign valid_next = load ? 1'b1 : (valid_reg && !down_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

endmodule

// ===== rtl/core/mau_acc_stage.sv =====
// accumulator stage: holds the 64-bit accumulator and sticky flag,
// which double as the result register; depends on mau_pkg
module mau_acc_stage
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         up_valid,
    input  mau_pkg::prod_stage_t         up_stage,
    output logic                         up_ready,
    input  logic                         down_ready,
    output logic                         out_valid,
    output logic [mau_pkg::ACC_W-1:0]    acc,
    output logic                         overflow
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [mau_pkg::ACC_W-1:0]  acc_reg;
    logic [mau_pkg::ACC_W-1:0]  acc_next;
    logic                       ovf_reg;
    logic                       ovf_next;
    logic [mau_pkg::ACC_W-1:0]  sum;
    logic                       sum_ovf;
    logic                       load;

    assign up_ready = !valid_reg || down_ready;
    assign load     = up_valid && up_ready;

    // wrapping add; overflow when addends agree in sign and the sum does not
    assign sum     = acc_reg + up_stage.product;
    assign sum_ovf = !(acc_reg[mau_pkg::ACC_W-1] ^ up_stage.product[mau_pkg::ACC_W-1])
                     && (acc_reg[mau_pkg::ACC_W-1] ^ sum[mau_pkg::ACC_W-1]);

    always_comb
    begin
        acc_next = acc_reg;
        ovf_next = ovf_reg;
        if (load)
        begin
            unique case (up_stage.mode)
                mau_pkg::MODE_MUL_S16, mau_pkg::MODE_MUL_U16,
                mau_pkg::MODE_MUL_S32, mau_pkg::MODE_MUL_U32:
                begin
                    acc_next = up_stage.product;
                end
                mau_pkg::MODE_MAC:
                begin
                    acc_next = sum;
                    ovf_next = ovf_reg || sum_ovf;
                end
                mau_pkg::MODE_LOAD_LOW:
                begin
                    acc_next = {acc_reg[mau_pkg::ACC_W-1:mau_pkg::WORD_W], up_stage.load_word};
                end
                mau_pkg::MODE_LOAD_HIGH:
                begin
                    acc_next = {up_stage.load_word, acc_reg[mau_pkg::WORD_W-1:0]};
                end
                mau_pkg::MODE_LOAD_FLAG:
                begin
                    ovf_next = up_stage.load_word[0];
                end
            endcase
        end
    end

    assign valid_next = load ? 1'b1 : (valid_reg && !down_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign out_valid = valid_reg;
    assign acc       = acc_reg;
    assign overflow  = ovf_reg;

endmodule

// ===== rtl/core/multiply_accumulate_unit.sv =====
// multiply-accumulate unit: each word passes the input, multiplier and accumulate
// registers in turn before its response word is valid; throughput one word per
// cycle while rsp.ready is high, the accumulate loop closing in the last stage
// rst_n is asynchronous, active low: clears all stage valids, the 64-bit
// accumulator and the sticky overflow flag
// depends on mau_pkg, mau_if, mau_input_stage, mau_mul_stage, mau_acc_stage
module multiply_accumulate_unit
(
    input  logic      clk,
    input  logic      rst_n,
    mau_req_if.sink   req,
    mau_rsp_if.source rsp
);

    // stage 1: mode decode into widened operands
    logic                       in_ready;
    logic                       opnd_valid;
    mau_pkg::opnd_stage_t       opnd_stage;

    // stage 2: 33x33 signed multiplier
    logic                       mul_ready;
    logic                       prod_valid;
    mau_pkg::prod_stage_t       prod_stage;

    // stage 3: accumulator, also the response register
    logic                       acc_ready;
    logic                       acc_fire;
    logic [mau_pkg::ACC_W-1:0]  acc;
    logic                       overflow;
    logic                       out_valid;

    mau_input_stage u_input
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (req.valid),
        .mode        (req.mode),
        .operand_a   (req.operand_a),
        .operand_b   (req.operand_b),
        .up_ready    (in_ready),
        .down_ready  (mul_ready),
        .stage_valid (opnd_valid),
        .stage       (opnd_stage)
    );

    mau_mul_stage u_mul
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (opnd_valid),
        .up_stage    (opnd_stage),
        .up_ready    (mul_ready),
        .down_ready  (acc_ready),
        .stage_valid (prod_valid),
        .stage       (prod_stage)
    );

    mau_acc_stage u_acc
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (prod_valid),
        .up_stage   (prod_stage),
        .up_ready   (acc_ready),
        .down_ready (rsp.ready),
        .out_valid  (out_valid),
        .acc        (acc),
        .overflow   (overflow)
    );

    // a word updates the accumulator on the edge it leaves the multiplier
    assign acc_fire = prod_valid && acc_ready;

    // each stage moves when the next is empty or moving, so a waiting
    // response only stalls the pipe once every stage is full
    assign req.ready    = in_ready;
    assign rsp.valid    = out_valid;
    assign rsp.acc_low  = acc[mau_pkg::WORD_W-1:0];
    assign rsp.acc_high = acc[mau_pkg::ACC_W-1:mau_pkg::WORD_W];
    assign rsp.overflow = overflow;

`ifndef SYNTHESIS
    // the sticky flag only clears through a load-flag word
    assert property (@(posedge clk) disable iff (!rst_n)
        (!overflow && $past(overflow)) |->
            $past(acc_fire && (prod_stage.mode == mau_pkg::MODE_LOAD_FLAG)))
    else $error("overflow flag cleared without a load-flag word");

    // the accumulator only moves when a word passes the accumulate stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(acc_fire) |-> $stable(acc))
    else $error("accumulator changed without an accumulate step");

    // the input only backs up when all three stages hold a word
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (opnd_valid && prod_valid && out_valid))
    else $error("request stalled with an empty stage");
`endif

endmodule

// ===== dv/tb_multiply_accumulate_unit.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the multiply-accumulate unit: directed corners, random
// operation streams, idle/stall phases and one long response back-pressure stretch
// depends on mau_pkg, mau_if and multiply_accumulate_unit from rtl/core
module tb_multiply_accumulate_unit;

    // accumulator predictor plus the queue of response words still owed by the block
    class mac_scoreboard;
        typedef struct {
            logic [mau_pkg::WORD_W-1:0] low;
            logic [mau_pkg::WORD_W-1:0] high;
            logic                       flag;
        } acc_word_t;

        logic [mau_pkg::ACC_W-1:0] acc  = '0;
        logic                      flag = 1'b0;
        acc_word_t                 owed_q[$];
        int                        errors        = 0;
        int                        requests      = 0;
        int                        checked       = 0;
        int                        overflow_hits = 0;

        function logic [mau_pkg::ACC_W-1:0] widen_half(logic [mau_pkg::HALF_W-1:0] h);
            return {{(mau_pkg::ACC_W-mau_pkg::HALF_W){h[mau_pkg::HALF_W-1]}}, h};
        endfunction

        // note one accepted request word and queue the accumulator it must leave behind
        function void note_request(mau_pkg::mode_t m, logic [mau_pkg::WORD_W-1:0] a,
                                   logic [mau_pkg::WORD_W-1:0] b);
            logic [mau_pkg::ACC_W-1:0] prod;
            logic [mau_pkg::ACC_W-1:0] sum;
            acc_word_t                 w;
            case (m)
                mau_pkg::MODE_MUL_S16:
                    acc = widen_half(a[mau_pkg::HALF_W-1:0])
                        * widen_half(b[mau_pkg::HALF_W-1:0]);
                mau_pkg::MODE_MUL_U16:
                    acc = {{(mau_pkg::ACC_W-mau_pkg::HALF_W){1'b0}}, a[mau_pkg::HALF_W-1:0]}
                        * {{(mau_pkg::ACC_W-mau_pkg::HALF_W){1'b0}}, b[mau_pkg::HALF_W-1:0]};
                mau_pkg::MODE_MUL_S32:
                    acc = {{mau_pkg::WORD_W{a[mau_pkg::WORD_W-1]}}, a}
                        * {{mau_pkg::WORD_W{b[mau_pkg::WORD_W-1]}}, b};
                mau_pkg::MODE_MUL_U32:
                    acc = {{mau_pkg::WORD_W{1'b0}}, a} * {{mau_pkg::WORD_W{1'b0}}, b};
                mau_pkg::MODE_MAC:
                begin
                    prod = widen_half(a[mau_pkg::HALF_W-1:0])
                         * widen_half(b[mau_pkg::HALF_W-1:0]);
                    sum  = acc + prod;
                    // same-sign addends with a sign flip in the sum
                    if (acc[mau_pkg::ACC_W-1] == prod[mau_pkg::ACC_W-1]
                        && sum[mau_pkg::ACC_W-1] != acc[mau_pkg::ACC_W-1])
                    begin
                        flag = 1'b1;
                        overflow_hits++;
                    end
                    acc = sum;
                end
                mau_pkg::MODE_LOAD_LOW:
                    acc[mau_pkg::WORD_W-1:0] = a;
                mau_pkg::MODE_LOAD_HIGH:
                    acc[mau_pkg::ACC_W-1:mau_pkg::WORD_W] = a;
                mau_pkg::MODE_LOAD_FLAG:
                    flag = a[0];
            endcase
            w.low  = acc[mau_pkg::WORD_W-1:0];
            w.high = acc[mau_pkg::ACC_W-1:mau_pkg::WORD_W];
            w.flag = flag;
            owed_q.push_back(w);
            requests++;
        endfunction

        function void check_response(logic [mau_pkg::WORD_W-1:0] low,
                                     logic [mau_pkg::WORD_W-1:0] high, logic ovf);
            acc_word_t w;
            if (owed_q.size() == 0)
            begin
                $display("%0t: unexpected response word low %h high %h overflow %b",
                         $time, low, high, ovf);
                errors++;
                return;
            end
            w = owed_q.pop_front();
            checked++;
            if (low !== w.low)
            begin
                $display("%0t: acc_low expected %h actual %h", $time, w.low, low);
                errors++;
            end
            if (high !== w.high)
            begin
                $display("%0t: acc_high expected %h actual %h", $time, w.high, high);
                errors++;
            end
            if (ovf !== w.flag)
            begin
                $display("%0t: overflow expected %b actual %b", $time, w.flag, ovf);
                errors++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    localparam int PIPE_LATENCY = 3;   // request accept to response valid
    localparam int HOLD_CYCLES  = 64;  // long response hold-off, far deeper than the pipe

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mau_req_if req_ch ();
    mau_rsp_if rsp_ch ();

    multiply_accumulate_unit uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    mac_scoreboard board;

    // idle and stall odds in percent, changed per phase by the main sequence
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int sent_words    = 0;

    // the main sequence bumps hold_requests; the response side serves each one
    // by counting down its own hold-off
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    always #4 clk = ~clk;

    // response side: check every accepted word, then pick next cycle's ready
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            board.check_response(rsp_ch.acc_low, rsp_ch.acc_high, rsp_ch.overflow);
        if (holds_served < hold_requests)
        begin
            hold_left = HOLD_CYCLES;
            holds_served++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // offer one request word, with random idle cycles ahead of it, and wait for accept;
    // valid stays high on return so back-to-back words never drop it
    task automatic send_request(input mau_pkg::mode_t m,
                                input logic [mau_pkg::WORD_W-1:0] a,
                                input logic [mau_pkg::WORD_W-1:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.mode      <= m;
        req_ch.operand_a <= a;
        req_ch.operand_b <= b;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        board.note_request(m, a, b);
        sent_words++;
    endtask

    // operands biased to the sign and width corners, with random upper halves
    function automatic logic [mau_pkg::WORD_W-1:0] pick_operand();
        logic [mau_pkg::WORD_W-1:0] word;
        logic [mau_pkg::HALF_W-1:0] half;
        word = $urandom();
        case ($urandom_range(3))
            0: half = 16'h8000;
            1: half = 16'h7FFF;
            2: half = 16'hFFFF;
            default: half = 16'h0001;
        endcase
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return {word[mau_pkg::WORD_W-1:mau_pkg::HALF_W], half};
            default: return word;
        endcase
    endfunction

    // park the accumulator near one of the signed limits, then run MAC steps at it
    // so the sticky flag actually gets exercised; sometimes load the flag from a random bit after
    task automatic overflow_probe();
        logic [mau_pkg::WORD_W-1:0] top_word;
        logic [mau_pkg::WORD_W-1:0] bottom_word;
        int                         macs;
        top_word    = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        // within a few halfword products of the wrap point
        bottom_word = top_word[mau_pkg::WORD_W-1] ? ($urandom() & 32'h3FFF_FFFF)
                                                  : ($urandom() | 32'hC000_0000);
        if ($urandom_range(1))
        begin
            send_request(mau_pkg::MODE_LOAD_HIGH, top_word, $urandom());
            send_request(mau_pkg::MODE_LOAD_LOW, bottom_word, $urandom());
        end
        else
        begin
            send_request(mau_pkg::MODE_LOAD_LOW, bottom_word, $urandom());
            send_request(mau_pkg::MODE_LOAD_HIGH, top_word, $urandom());
        end
        macs = $urandom_range(6, 1);
        repeat (macs)
            send_request(mau_pkg::MODE_MAC, pick_operand(), pick_operand());
        if ($urandom_range(3) == 0)
            send_request(mau_pkg::MODE_LOAD_FLAG, $urandom(), $urandom());
    endtask

    // mix of overflow probes and single random operations until n more words went in
    task automatic run_random(input int n);
        int target;
        target = sent_words + n;
        while (sent_words < target)
        begin
            if ($urandom_range(99) < 20)
                overflow_probe();
            else
                send_request(mau_pkg::mode_t'($urandom_range(7)), pick_operand(),
                             pick_operand());
        end
    endtask

    initial
    begin
        board            = new;
        req_ch.valid     = 1'b0;
        req_ch.mode      = mau_pkg::MODE_MUL_S16;
        req_ch.operand_a = '0;
        req_ch.operand_b = '0;
        rsp_ch.ready     = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 16-bit multiplies ignore the upper halves
        send_request(mau_pkg::MODE_MUL_S16, 32'hFFFF_8000, 32'h1234_8000);
        send_request(mau_pkg::MODE_MUL_S16, 32'h0000_7FFF, 32'hFFFF_8000);
        send_request(mau_pkg::MODE_MUL_U16, 32'h8765_FFFF, 32'hABCD_FFFF);
        send_request(mau_pkg::MODE_MUL_U16, 32'hFFFF_0000, 32'h0000_ABCD);
        // 32-bit multiplies at the sign corners
        send_request(mau_pkg::MODE_MUL_S32, 32'h8000_0000, 32'h8000_0000);
        send_request(mau_pkg::MODE_MUL_S32, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(mau_pkg::MODE_MUL_S32, 32'hFFFF_FFFF, 32'h0000_0001);
        send_request(mau_pkg::MODE_MUL_U32, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(mau_pkg::MODE_MUL_U32, 32'h8000_0000, 32'h0000_0002);
        // positive overflow: max positive plus one wraps and sets the flag
        send_request(mau_pkg::MODE_LOAD_HIGH, 32'h7FFF_FFFF, 32'hDEAD_BEEF);
        send_request(mau_pkg::MODE_LOAD_LOW, 32'hFFFF_FFFF, 32'hDEAD_BEEF);
        send_request(mau_pkg::MODE_MAC, 32'hFFFF_0001, 32'h5555_0001);
        // flag is sticky across a further MAC step
        send_request(mau_pkg::MODE_MAC, 32'h0000_0001, 32'h0000_0001);
        // flag load takes only bit 0
        send_request(mau_pkg::MODE_LOAD_FLAG, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_request(mau_pkg::MODE_LOAD_FLAG, 32'h0000_0001, 32'h0000_0000);
        // multiplies leave the flag alone
        send_request(mau_pkg::MODE_MUL_U32, 32'h1234_5678, 32'h9ABC_DEF0);
        send_request(mau_pkg::MODE_LOAD_FLAG, 32'h0000_0000, 32'hFFFF_FFFF);
        // negative overflow: most negative minus one
        send_request(mau_pkg::MODE_LOAD_HIGH, 32'h8000_0000, 32'h0);
        send_request(mau_pkg::MODE_LOAD_LOW, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(mau_pkg::MODE_MAC, 32'h0000_FFFF, 32'h0000_0001);
        // mixed signs never overflow
        send_request(mau_pkg::MODE_LOAD_FLAG, 32'hFFFF_FFFE, 32'h0);
        send_request(mau_pkg::MODE_MAC, 32'h0000_8000, 32'h0000_7FFF);
        // largest positive product carried across the word boundary into the sign
        send_request(mau_pkg::MODE_LOAD_HIGH, 32'h7FFF_FFFF, 32'h0);
        send_request(mau_pkg::MODE_LOAD_LOW, 32'hC000_0000, 32'h0);
        send_request(mau_pkg::MODE_MAC, 32'h0000_8000, 32'hFFFF_8000);

        // random phases: free flowing, sender gaps, receiver stalls, both
        run_random(300);
        src_idle_pct = 53;
        run_random(280);
        src_idle_pct  = 0;
        snk_stall_pct = 53;
        run_random(280);
        src_idle_pct  = 26;
        snk_stall_pct = 26;
        run_random(250);

        // back-pressure: response side holds off while requests keep coming,
        // the pipe fills and the request side must stall
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_requests++;
        run_random(40);
        req_ch.valid <= 1'b0;

        // drain, then give stray words a chance to show up
        while (board.pending() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 8) @(posedge clk);

        $display("covered %0d request words, %0d response words checked, %0d MAC overflows",
                 board.requests, board.checked, board.overflow_hits);
        $display("phases: no gaps, sender gaps, receiver stalls, both, %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (board.errors == 0 && board.pending() == 0)
            $display("tb_multiply_accumulate_unit: done, clean");
        else
            $display("tb_multiply_accumulate_unit: done, errors");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("timeout with %0d response words outstanding", board.pending());
        $display("tb_multiply_accumulate_unit: done, errors");
        $finish;
    end

endmodule
